// File: rtl/pwmsl_pkg.sv
// Shared types, constants and register codes of the four channel PWM slew limiter.
`timescale 1ns / 1ps
package pwmsl_pkg;

	localparam int CHANNELS = 4;
	localparam int DATA_W   = 16;
	localparam int CHAN_W   = 3;
	localparam int CFG_IDX_W = 2;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register indexes of the configuration port
	localparam cfg_idx_t CFG_MIN_VALID = 2'd0;
	localparam cfg_idx_t CFG_MAX_VALID = 2'd1;
	localparam cfg_idx_t CFG_MAX_STEP  = 2'd2;

	// Reset values of the configuration registers
	localparam data_t MIN_VALID_RST = 16'd4000;
	localparam data_t MAX_VALID_RST = 16'd20000;
	localparam data_t MAX_STEP_RST  = 16'd200;

	// Index reported when every channel of a frame is in the window
	localparam chan_t NO_BAD_CHANNEL = chan_t'(CHANNELS);

	typedef struct packed {
		data_t min_valid;
		data_t max_valid;
		data_t max_step;
	} cfg_t;

	typedef struct packed {
		logic  in_window;
		data_t next_held;
	} lane_res_t;

endpackage

// File: rtl/pwmsl_lane.sv
// One channel lane: window check and slew of the held value toward the request.
`timescale 1ns / 1ps
module pwmsl_lane (
	input  pwmsl_pkg::data_t    request,
	input  pwmsl_pkg::data_t    held,
	input  pwmsl_pkg::cfg_t     cfg,
	output pwmsl_pkg::lane_res_t res
);
	import pwmsl_pkg::*;

	logic [DATA_W:0] down_gap;
	logic [DATA_W:0] up_gap;
	logic [DATA_W:0] step_ext;

	assign down_gap = {1'b0, held} - {1'b0, request};
	assign up_gap   = {1'b0, request} - {1'b0, held};
	assign step_ext = {1'b0, cfg.max_step};

	// Check the request against the window; jump on an unset held value,
	// else move by at most one step
	always_comb begin
		res.in_window = (request >= cfg.min_valid) && (request <= cfg.max_valid);
		if (held == '0) begin
			res.next_held = request;
		end else if ((held > request) && (down_gap > step_ext)) begin
			res.next_held = held - cfg.max_step;
		end else if ((request > held) && (up_gap > step_ext)) begin
			res.next_held = held + cfg.max_step;
		end else begin
			res.next_held = request;
		end
	end

endmodule

// File: rtl/four_channel_pwm_slew_limiter.sv
// Top level of the four channel PWM slew limiter: input register, lanes, result register.
// Throughput: one frame per cycle unless the result word stalls; a frame waits in the
// input register until the result register frees up. The four lanes and the validity
// prefix chain sit between those registers, held values update in the same pass.
// Input stall rises only while a loaded frame waits behind a stalled result word.
// Reset: asynchronous, active low; clears held values and duties to zero, loads the
// window and step registers with their defaults, empties both registers.
`timescale 1ns / 1ps
module four_channel_pwm_slew_limiter (
	input  logic                  clk,
	input  logic                  arst_n,
	// frame input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pwmsl_pkg::data_t      request_0,
	input  pwmsl_pkg::data_t      request_1,
	input  pwmsl_pkg::data_t      request_2,
	input  pwmsl_pkg::data_t      request_3,
	// result output
	output logic                  out_valid,
	input  logic                  out_stall,
	output pwmsl_pkg::data_t      duty_0,
	output pwmsl_pkg::data_t      duty_1,
	output pwmsl_pkg::data_t      duty_2,
	output pwmsl_pkg::data_t      duty_3,
	output logic                  applied,
	output pwmsl_pkg::chan_t      first_bad_channel,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  pwmsl_pkg::cfg_idx_t   cfg_index,
	input  pwmsl_pkg::data_t      cfg_data
);
	import pwmsl_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	data_t     req_s1   [CHANNELS];
	data_t     held_q   [CHANNELS];
	data_t     duty_q   [CHANNELS];
	lane_res_t lane_res [CHANNELS];
	logic [CHANNELS-1:0] ok_prefix;
	logic      out_valid_q;
	logic      applied_q;
	chan_t     bad_q;
	chan_t     first_bad;
	logic      advance;
	logic      accept;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_valid <= MIN_VALID_RST;
			cfg_q.max_valid <= MAX_VALID_RST;
			cfg_q.max_step  <= MAX_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_VALID: cfg_q.min_valid <= cfg_data;
				CFG_MAX_VALID: cfg_q.max_valid <= cfg_data;
				CFG_MAX_STEP:  cfg_q.max_step  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: advance the loaded frame whenever the result register frees up
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1[0] <= request_0;
			req_s1[1] <= request_1;
			req_s1[2] <= request_2;
			req_s1[3] <= request_3;
		end
	end

	// Channel lanes
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		pwmsl_lane u_lane (
			.request (req_s1[c]),
			.held    (held_q[c]),
			.cfg     (cfg_q),
			.res     (lane_res[c])
		);
	end

	// Validity prefix chain and first bad channel
	always_comb begin
		ok_prefix[0] = lane_res[0].in_window;
		for (int c = 1; c < CHANNELS; c++) begin
			ok_prefix[c] = ok_prefix[c-1] && lane_res[c].in_window;
		end
		first_bad = NO_BAD_CHANNEL;
		for (int c = CHANNELS - 1; c >= 0; c--) begin
			if (!lane_res[c].in_window) begin
				first_bad = chan_t'(c);
			end
		end
	end

	// Held values and applied duties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				held_q[c] <= '0;
				duty_q[c] <= '0;
			end
		end else if (advance) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (ok_prefix[c]) begin
					held_q[c] <= lane_res[c].next_held;
				end
				if (ok_prefix[CHANNELS-1]) begin
					duty_q[c] <= lane_res[c].next_held;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			applied_q <= ok_prefix[CHANNELS-1];
			bad_q     <= first_bad;
		end
	end

	// Duties move only on advance, so they hold while the result word is stalled
	assign out_valid         = out_valid_q;
	assign duty_0            = duty_q[0];
	assign duty_1            = duty_q[1];
	assign duty_2            = duty_q[2];
	assign duty_3            = duty_q[3];
	assign applied           = applied_q;
	assign first_bad_channel = bad_q;

endmodule

// File: rtl/pwmsl_checker.sv
// Port level checks for the four channel PWM slew limiter, bound to the top level.
`timescale 1ns / 1ps
module pwmsl_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input pwmsl_pkg::data_t    duty_0,
	input pwmsl_pkg::data_t    duty_1,
	input pwmsl_pkg::data_t    duty_2,
	input pwmsl_pkg::data_t    duty_3,
	input logic                applied,
	input pwmsl_pkg::chan_t    first_bad_channel
);
	import pwmsl_pkg::*;

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty_0) && $stable(duty_1)
			&& $stable(duty_2) && $stable(duty_3) && $stable(applied)
			&& $stable(first_bad_channel))
		else $error("result word changed while stalled");

	// Applied flag agrees with the bad channel index
	a_applied_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (applied == (first_bad_channel == NO_BAD_CHANNEL)))
		else $error("applied flag disagrees with first bad channel");

	// Bad channel index stays within the channel count
	a_bad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (first_bad_channel <= NO_BAD_CHANNEL))
		else $error("first bad channel out of range");

	// Input backpressure only comes from a stalled result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

endmodule

bind four_channel_pwm_slew_limiter pwmsl_checker u_pwmsl_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.duty_0            (duty_0),
	.duty_1            (duty_1),
	.duty_2            (duty_2),
	.duty_3            (duty_3),
	.applied           (applied),
	.first_bad_channel (first_bad_channel)
);
